// File: hdl/strl_pkg.sv
package strl_pkg;

   localparam int NAME_W = 64;
   localparam int WORD_W = 32;
   localparam int SLOT_W = 6;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_NAME,
      OP_RAW,
      OP_VIRT
   } strl_op_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } strl_state_type;

   typedef struct packed {
      logic [NAME_W-1:0] name;
      logic [WORD_W-1:0] raw_start;
      logic [WORD_W-1:0] raw_length;
      logic [WORD_W-1:0] virt_start;
      logic [WORD_W-1:0] virt_length;
   } strl_entry_type;

endpackage

// File: hdl/section_table_range_lookup.sv
// A write request is taken while idle; its response strobes on the next cycle and busy stays low.
// A query request raises busy and scans one table entry per cycle through the table memory,
// whose read is registered; the response strobes on the first matching entry or after the last
// entry, and the next request is taken in the cycle of that strobe.
// Synchronous active-high reset clears all entry valid bits and returns the sequencer to idle.
// Responses cannot be stalled; each is presented for exactly one cycle.
module section_table_range_lookup
   import strl_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [SLOT_W-1:0] req_entry_index,
   input  logic [NAME_W-1:0] req_name_key,
   input  logic [WORD_W-1:0] req_raw_start,
   input  logic [WORD_W-1:0] req_raw_length,
   input  logic [WORD_W-1:0] req_virt_start,
   input  logic [WORD_W-1:0] req_virt_length,
   input  logic [WORD_W-1:0] req_query_address,
   output logic              rsp_strobe,
   output logic              rsp_found,
   output logic [SLOT_W-1:0] rsp_match_index
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   strl_state_type       state_ff, state_in;
   strl_op_type          op_ff, op_in;
   logic [NAME_W-1:0]    key_ff, key_in;
   logic [WORD_W-1:0]    qaddr_ff, qaddr_in;
   logic [IDX_W-1:0]     addr_ff, addr_in;
   logic [IDX_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 live_ff, live_in;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [SLOT_W-1:0]    rsp_index_ff, rsp_index_in;

   logic                 accept;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   strl_entry_type       wr_entry;
   strl_entry_type       rd_entry;
   logic                 rd_en;
   logic [WORD_W-1:0]    sel_start;
   logic [WORD_W-1:0]    sel_length;
   logic [WORD_W:0]      range_end;
   logic                 in_range;
   logic                 match;
   logic                 hit;

   assign accept  = start && !busy;
   assign wr_addr = IDX_W'(req_entry_index);
   assign wr_en   = accept && (strl_op_type'(req_opcode) == OP_WRITE)
                    && (32'(req_entry_index) < 32'(TABLE_ENTRIES));
   assign rd_en   = (state_ff == ST_SCAN);

   assign wr_entry = '{name:        req_name_key,
                       raw_start:   req_raw_start,
                       raw_length:  req_raw_length,
                       virt_start:  req_virt_start,
                       virt_length: req_virt_length};

   strl_ram #(
      .WIDTH ($bits(strl_entry_type)),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (addr_ff),
      .rd_data (rd_entry)
   );

   // The single compare unit: a name equality or one 33-bit end sum with its bounds test.
   always_comb begin
      sel_start  = (op_ff == OP_RAW) ? rd_entry.raw_start : rd_entry.virt_start;
      sel_length = (op_ff == OP_RAW) ? rd_entry.raw_length : rd_entry.virt_length;
      range_end  = {1'b0, sel_start} + {1'b0, sel_length};
      in_range   = (qaddr_ff >= sel_start) && ({1'b0, qaddr_ff} < range_end);
      case (op_ff)
         OP_NAME: match = (rd_entry.name == key_ff);
         OP_RAW,
         OP_VIRT: match = in_range;
         default: match = 1'b0;
      endcase
      hit = live_ff && valid_ff[cmp_idx_ff] && match;
   end

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      qaddr_in      = qaddr_ff;
      addr_in       = addr_ff;
      cmp_idx_in    = cmp_idx_ff;
      live_in       = live_ff;
      valid_in      = valid_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_index_in  = '0;

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (strl_op_type'(req_opcode) == OP_WRITE) begin
                  rsp_strobe_in = 1'b1;
               end else begin
                  state_in = ST_SCAN;
                  op_in    = strl_op_type'(req_opcode);
                  key_in   = req_name_key;
                  qaddr_in = req_query_address;
                  addr_in  = '0;
                  live_in  = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // Reads run one entry ahead of the compare; the address holds at the last entry.
            cmp_idx_in = addr_ff;
            live_in    = 1'b1;
            if (addr_ff != LAST_IDX) begin
               addr_in = addr_ff + IDX_W'(1);
            end
            if (hit || (live_ff && (cmp_idx_ff == LAST_IDX))) begin
               state_in      = ST_IDLE;
               live_in       = 1'b0;
               rsp_strobe_in = 1'b1;
               rsp_found_in  = hit;
               rsp_index_in  = hit ? SLOT_W'(cmp_idx_ff) : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            live_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         live_ff       <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      qaddr_ff     <= qaddr_in;
      addr_ff      <= addr_in;
      cmp_idx_ff   <= cmp_idx_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;

`ifndef NO_ASSERTIONS
   // A query raises busy in the cycle after its acceptance.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (strl_op_type'(req_opcode) != OP_WRITE)) |=> busy)
      else $error("query request did not raise busy");

   // A write is answered on the next cycle with a miss.
   a_write_ack: assert property (@(posedge clock) disable iff (reset)
      (accept && (strl_op_type'(req_opcode) == OP_WRITE)) |=> (rsp_strobe && !rsp_found))
      else $error("write request not acknowledged as a miss");

   // A reported hit always names a valid entry.
   a_hit_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_found) |-> valid_ff[IDX_W'(rsp_match_index)])
      else $error("hit reported on an entry that is not valid");

   // A response is only ever presented once the sequencer is idle again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response presented while still scanning");
`endif

endmodule

// File: hdl/strl_ram.sv
module strl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import strl_pkg::*;

   localparam int REQUEST_TOTAL = 550;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } lookup_result_type;

   class section_scoreboard;
      localparam int SLOTS = 64;

      logic [NAME_W-1:0] names [SLOTS];
      logic [WORD_W-1:0] raw_starts [SLOTS];
      logic [WORD_W-1:0] raw_lengths [SLOTS];
      logic [WORD_W-1:0] virt_starts [SLOTS];
      logic [WORD_W-1:0] virt_lengths [SLOTS];
      bit                valid [SLOTS];
      lookup_result_type pending_hits [$];
      int                mismatch_count;

      function new();
         mismatch_count = 0;
         foreach (valid[i]) valid[i] = 1'b0;
      endfunction

      // The end of a range is a 33-bit sum, so a section at the top of the space never wraps.
      function bit covers(logic [WORD_W-1:0] addr, logic [WORD_W-1:0] base,
                          logic [WORD_W-1:0] len);
         logic [WORD_W:0] stop;
         stop = {1'b0, base} + {1'b0, len};
         return (addr >= base) && ({1'b0, addr} < stop);
      endfunction

      function lookup_result_type find_lowest_slot(strl_op_type op, logic [NAME_W-1:0] key,
                                                   logic [WORD_W-1:0] addr);
         lookup_result_type r;
         bit                hit;
         r = '0;
         for (int i = 0; i < SLOTS; i++) begin
            if (valid[i]) begin
               case (op)
                  OP_NAME: hit = (names[i] == key);
                  OP_RAW:  hit = covers(addr, raw_starts[i], raw_lengths[i]);
                  default: hit = covers(addr, virt_starts[i], virt_lengths[i]);
               endcase
               if (hit) begin
                  r.found = 1'b1;
                  r.slot  = SLOT_W'(i);
                  break;
               end
            end
         end
         return r;
      endfunction

      function void note_request(strl_op_type op, logic [SLOT_W-1:0] slot,
                                 logic [NAME_W-1:0] key, logic [WORD_W-1:0] rs,
                                 logic [WORD_W-1:0] rl, logic [WORD_W-1:0] vs,
                                 logic [WORD_W-1:0] vl, logic [WORD_W-1:0] addr);
         if (op == OP_WRITE) begin
            names[slot]        = key;
            raw_starts[slot]   = rs;
            raw_lengths[slot]  = rl;
            virt_starts[slot]  = vs;
            virt_lengths[slot] = vl;
            valid[slot]        = 1'b1;
            pending_hits.push_back('0);
         end else begin
            pending_hits.push_back(find_lowest_slot(op, key, addr));
         end
      endfunction

      task report_mismatch(string what, logic [NAME_W-1:0] got, logic [NAME_W-1:0] want);
         if (mismatch_count < 40)
            $display("tb: %s mismatch at %0t: got %0h, expected %0h", what, $time, got, want);
         mismatch_count++;
      endtask

      task check_response(logic found, logic [SLOT_W-1:0] slot);
         lookup_result_type want;
         if (pending_hits.size() == 0) begin
            report_mismatch("unexpected response", NAME_W'({found, slot}), '0);
         end else begin
            want = pending_hits.pop_front();
            if (found !== want.found)
               report_mismatch("found", NAME_W'(found), NAME_W'(want.found));
            if (slot !== want.slot)
               report_mismatch("match_index", NAME_W'(slot), NAME_W'(want.slot));
         end
      endtask

      function int pending();
         return pending_hits.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = OP_WRITE;
   logic [SLOT_W-1:0] req_entry_index = '0;
   logic [NAME_W-1:0] req_name_key = '0;
   logic [WORD_W-1:0] req_raw_start = '0;
   logic [WORD_W-1:0] req_raw_length = '0;
   logic [WORD_W-1:0] req_virt_start = '0;
   logic [WORD_W-1:0] req_virt_length = '0;
   logic [WORD_W-1:0] req_query_address = '0;
   logic              rsp_strobe;
   logic              rsp_found;
   logic [SLOT_W-1:0] rsp_match_index;

   section_scoreboard sb = new();

   section_table_range_lookup DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_opcode(req_opcode),
      .req_entry_index(req_entry_index),
      .req_name_key(req_name_key),
      .req_raw_start(req_raw_start),
      .req_raw_length(req_raw_length),
      .req_virt_start(req_virt_start),
      .req_virt_length(req_virt_length),
      .req_query_address(req_query_address),
      .rsp_strobe(rsp_strobe),
      .rsp_found(rsp_found),
      .rsp_match_index(rsp_match_index)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   // Values read here are those that stood before the edge, so acceptance and responses
   // are seen exactly as the block sees them.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe === 1'b1) sb.check_response(rsp_found, rsp_match_index);
         if (start && busy === 1'b0)
            sb.note_request(strl_op_type'(req_opcode), req_entry_index, req_name_key,
                            req_raw_start, req_raw_length, req_virt_start,
                            req_virt_length, req_query_address);
      end
   end

   task send_request(input strl_op_type op, input logic [SLOT_W-1:0] slot,
                     input logic [NAME_W-1:0] key, input logic [WORD_W-1:0] rs,
                     input logic [WORD_W-1:0] rl, input logic [WORD_W-1:0] vs,
                     input logic [WORD_W-1:0] vl, input logic [WORD_W-1:0] addr);
      req_opcode        <= op;
      req_entry_index   <= slot;
      req_name_key      <= key;
      req_raw_start     <= rs;
      req_raw_length    <= rl;
      req_virt_start    <= vs;
      req_virt_length   <= vl;
      req_query_address <= addr;
      start             <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   function automatic logic [WORD_W-1:0] pick_length();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return $urandom_range(1, 16);
         2: return $urandom_range(1, 4096);
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] pick_start();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 4095);
         1: return 32'hFFFF_F000 | $urandom_range(0, 4095);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [NAME_W-1:0] pick_name();
      case ($urandom_range(0, 5))
         0: return 64'h0000_0074_7865_742E;
         1: return 64'h0000_0061_7461_642E;
         2: return '0;
         3: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mostly aims at the edges of a section already in the table, so that hits are common.
   function automatic logic [WORD_W-1:0] probe_address(bit raw_side);
      int                slot;
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] len;
      slot = $urandom_range(0, 63);
      if (!sb.valid[slot] || $urandom_range(0, 4) == 0) return $urandom;
      base = raw_side ? sb.raw_starts[slot] : sb.virt_starts[slot];
      len  = raw_side ? sb.raw_lengths[slot] : sb.virt_lengths[slot];
      case ($urandom_range(0, 4))
         0: return base;
         1: return base + len - 1;
         2: return base + len;
         3: return base - 1;
         default: return (len == 0) ? base : base + ($urandom % len);
      endcase
   endfunction

   initial begin
      int                sent;
      int                burst;
      int                gap;
      int                slot;
      strl_op_type       op;
      logic [NAME_W-1:0] key;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty table, then sections at the extremes of both address spaces.
      send_request(OP_NAME, 0, '0, 0, 0, 0, 0, 0);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, 0);
      send_request(OP_VIRT, 0, '0, 0, 0, 0, 0, '1);
      send_request(OP_WRITE, 0, '1, 0, 0, '1, '1, 0);
      send_request(OP_WRITE, 63, '0, 0, '1, 0, 1, '1);
      send_request(OP_NAME, 0, '1, 0, 0, 0, 0, 0);
      send_request(OP_NAME, 0, '0, 0, 0, 0, 0, 0);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, 0);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, 32'hFFFF_FFFE);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, '1);
      send_request(OP_VIRT, 0, '0, 0, 0, 0, 0, '1);
      send_request(OP_VIRT, 0, '0, 0, 0, 0, 0, 0);
      send_request(OP_VIRT, 0, '0, 0, 0, 0, 0, 1);
      // A second section with the same name and an overlapping range: the lower slot wins.
      send_request(OP_WRITE, 5, '0, 100, 10, 100, 10, 0);
      send_request(OP_NAME, 0, '0, 0, 0, 0, 0, 0);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, 100);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, 109);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, 110);
      send_request(OP_VIRT, 0, '0, 0, 0, 0, 0, 109);
      send_request(OP_VIRT, 0, '0, 0, 0, 0, 0, 110);
      send_request(OP_WRITE, 5, 64'h0000_0074_7865_742E, 0, 0, 0, 0, 0);
      send_request(OP_NAME, 0, '0, 0, 0, 0, 0, 0);
      send_request(OP_NAME, 0, 64'h0000_0074_7865_742E, 0, 0, 0, 0, 0);
      send_request(OP_WRITE, 62, '1, 32'hFFFF_FF00, 256, 0, 0, 0);
      send_request(OP_RAW, 0, '0, 0, 0, 0, 0, '1);

      sent = 0;
      while (sent < REQUEST_TOTAL) begin
         burst = $urandom_range(1, 12);
         repeat (burst) begin
            if ($urandom_range(0, 99) < 35) begin
               slot = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
               send_request(OP_WRITE, SLOT_W'(slot), pick_name(), pick_start(), pick_length(),
                            pick_start(), pick_length(), $urandom);
            end else begin
               op = strl_op_type'($urandom_range(1, 3));
               slot = $urandom_range(0, 63);
               if (op == OP_NAME && sb.valid[slot] && $urandom_range(0, 1) == 1)
                  key = sb.names[slot];
               else
                  key = pick_name();
               send_request(op, SLOT_W'($urandom), key, $urandom, $urandom, $urandom,
                            $urandom, probe_address(op == OP_RAW));
            end
            sent++;
         end
         case ($urandom_range(0, 3))
            0: gap = 0;
            1: gap = $urandom_range(1, 3);
            2: gap = $urandom_range(4, 20);
            default: gap = $urandom_range(20, 80);
         endcase
         if (sent < REQUEST_TOTAL && gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b0;

      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (70) @(posedge clock);

      if (sb.mismatch_count == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// File: files.f
hdl/strl_pkg.sv
hdl/strl_ram.sv
hdl/section_table_range_lookup.sv
tb/testbench.sv
